// File: rtl/nearest_table_value_coder_assert.svh
// ---------------------------------------------------------------------------
// Nearest table value coder: assertion macros
// Shared concurrent check forms. They expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef NEAREST_TABLE_VALUE_CODER_ASSERT_SVH
`define NEAREST_TABLE_VALUE_CODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTVC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ntvc_pkg.sv
// ---------------------------------------------------------------------------
// ntvc_pkg
// Shared codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntvc_pkg;

  // table entry width
  localparam int VALUE_BITS = 16;

  // transaction kinds
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_MARK = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [7:0] VALID_MARK = 8'h80;
  localparam logic [7:0] INDEX_MASK = 8'h7F;

  // table read address select
  typedef logic [2:0] rd_sel_t;
  localparam rd_sel_t RD_ZERO = 3'd0;
  localparam rd_sel_t RD_LO   = 3'd1;
  localparam rd_sel_t RD_HI   = 3'd2;
  localparam rd_sel_t RD_MID  = 3'd3;
  localparam rd_sel_t RD_CODE = 3'd4;

  typedef struct packed {
    logic    capture;
    logic    wr;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    set_lo;
    logic    take_lo;
    logic    take_hi;
    logic    take_mid;
    logic    pick_lo;
    logic    pick_hi;
    logic    pick_near;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic lt;        // search value below table read data
    logic gt;        // search value above table read data
    logic span_gt1;  // hi - lo > 1
  } stat_t;

endpackage

// File: rtl/nearest_table_value_coder.sv
// Encode probes entry 0, then the low and high ends of the searched range; it stops there
// when the value is below the low end or above the high end, else it runs mid probes
// (at most 7 for 128 entries). Load does one write, decode one read.
// One transaction at a time; the next is accepted the cycle after the result
// is registered. Table probes share the RAM's single registered read port.
// Reset (rst, synchronous): idle, no result pending, table_size = 1; table not cleared.
// ---------------------------------------------------------------------------
// nearest_table_value_coder
// Sorted resolution table with nearest-value encode and code decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_table_value_coder #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: table_size
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [6:0]  entry_index,
  input  logic [15:0] entry_value,
  input  logic [15:0] dpi,
  input  logic [7:0]  code,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_out,
  output logic [15:0] value_out,
  output logic [1:0]  status
);

  ntvc_pkg::cmd_t  cmd;
  ntvc_pkg::stat_t st;
  logic            busy;
  logic            in_accept;

  // A transaction enters only while the sequencer is idle; a finished result
  // sits in the output register so the next transaction can start meanwhile.
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  // Sequencer: load writes one entry, decode does one read, encode runs the
  // bracketed binary search (first entry, zero skip, end clamps, mid probes).
  ntvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .op        (op),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath owns the table RAM, size register, bounds and result registers.
  ntvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .op          (op),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .dpi         (dpi),
    .code        (code),
    .code_out    (code_out),
    .value_out   (value_out),
    .status      (status)
  );

endmodule

// File: rtl/ntvc_ram.sv
// ---------------------------------------------------------------------------
// ntvc_ram
// Generic single write port / single read port RAM, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ntvc_ctrl.sv
// ---------------------------------------------------------------------------
// ntvc_ctrl
// Sequencer: one transaction at a time, binary search probe loop,
// output register handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_table_value_coder_assert.svh"

module ntvc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_accept,
  input  logic [1:0]     op,
  input  logic           out_stall,
  input  ntvc_pkg::stat_t st,
  output ntvc_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RDC  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_E0   = 4'd4;
  localparam logic [3:0] S_RDLO = 4'd5;
  localparam logic [3:0] S_ELO  = 4'd6;
  localparam logic [3:0] S_RDHI = 4'd7;
  localparam logic [3:0] S_EHI  = 4'd8;
  localparam logic [3:0] S_LOOP = 4'd9;
  localparam logic [3:0] S_EMID = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.capture = 1'b1;
          case (op)
            ntvc_pkg::OP_LOAD: state_next = S_WR;
            ntvc_pkg::OP_ENC:  state_next = S_RD0;
            ntvc_pkg::OP_DEC:  state_next = S_RDC;
            default:           state_next = S_FIN;
          endcase
        end
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_FIN;
      end
      S_RDC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ntvc_pkg::RD_CODE;
        state_next = S_FIN;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ntvc_pkg::RD_ZERO;
        state_next = S_E0;
      end
      S_E0: begin
        cmd.set_lo = 1'b1;
        state_next = S_RDLO;
      end
      S_RDLO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ntvc_pkg::RD_LO;
        state_next = S_ELO;
      end
      S_ELO: begin
        cmd.take_lo = 1'b1;
        if (st.lt) begin
          cmd.pick_lo = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next  = S_RDHI;
        end
      end
      S_RDHI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ntvc_pkg::RD_HI;
        state_next = S_EHI;
      end
      S_EHI: begin
        cmd.take_hi = 1'b1;
        if (st.gt) begin
          cmd.pick_hi = 1'b1;
          state_next  = S_FIN;
        end else begin
          state_next  = S_LOOP;
        end
      end
      S_LOOP: begin
        if (st.span_gt1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ntvc_pkg::RD_MID;
          state_next = S_EMID;
        end else begin
          cmd.pick_near = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_EMID: begin
        cmd.take_mid = 1'b1;
        state_next   = S_LOOP;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign busy = (state != S_IDLE);

  `NTVC_ASSERT_NEXT(a_busy_after_accept, in_accept, state != S_IDLE, "accept left block idle")
  `NTVC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  `NTVC_ASSERT_NEXT(a_fin_hold, state == S_FIN && out_valid && out_stall,
    state == S_FIN && out_valid, "finish left while output stalled")

endmodule

// File: rtl/ntvc_dp.sv
// ---------------------------------------------------------------------------
// ntvc_dp
// Datapath: table RAM, size register, search bounds, result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_table_value_coder_assert.svh"

module ntvc_dp #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  ntvc_pkg::cmd_t  cmd,
  output ntvc_pkg::stat_t st,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic [1:0]      op,
  input  logic [6:0]      entry_index,
  input  logic [15:0]     entry_value,
  input  logic [15:0]     dpi,
  input  logic [7:0]      code,
  output logic [7:0]      code_out,
  output logic [15:0]     value_out,
  output logic [1:0]      status
);

  localparam int VALUE_BITS = ntvc_pkg::VALUE_BITS;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int EW = IW + 1;

  logic [7:0]            table_size;
  logic [EW-1:0]         eff;
  logic [1:0]            op_r;
  logic [6:0]            idx_r;
  logic [VALUE_BITS-1:0] ev_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [7:0]            code_r;
  logic [IW-1:0]         lo;
  logic [IW-1:0]         hi;
  logic [IW-1:0]         pick;
  logic [VALUE_BITS-1:0] e_lo;
  logic [VALUE_BITS-1:0] e_hi;
  logic [EW-1:0]         bsum;
  logic [IW-1:0]         mid;
  logic [7:0]            code_idx;
  logic [VALUE_BITS-1:0] dlo;
  logic [VALUE_BITS-1:0] dhi;
  logic                  ram_we;
  logic [IW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;
  logic [7:0]            code_out_next;
  logic [15:0]           value_out_next;
  logic [1:0]            status_next;

  // effective size: clamp to 1..MAX_ENTRIES
  always_comb begin
    if (table_size == 8'd0) begin
      eff = EW'(1);
    end else if ({1'b0, table_size} > 9'(MAX_ENTRIES)) begin
      eff = EW'(MAX_ENTRIES);
    end else begin
      eff = EW'(table_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 8'd1;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  assign bsum     = {1'b0, lo} + {1'b0, hi};
  assign mid      = bsum[IW:1];
  assign code_idx = code_r & ntvc_pkg::INDEX_MASK;

  always_comb begin
    case (cmd.rd_sel)
      ntvc_pkg::RD_ZERO: raddr = '0;
      ntvc_pkg::RD_LO:   raddr = lo;
      ntvc_pkg::RD_HI:   raddr = hi;
      ntvc_pkg::RD_MID:  raddr = mid;
      ntvc_pkg::RD_CODE: raddr = code_idx[IW-1:0];
      default:           raddr = '0;
    endcase
  end

  assign ram_we = cmd.wr && ({1'b0, idx_r} < 8'(MAX_ENTRIES));

  ntvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r[IW-1:0]),
    .wdata (ev_r),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st.lt       = (v_r < rdata);
  assign st.gt       = (v_r > rdata);
  assign st.span_gt1 = ({1'b0, hi} > ({1'b0, lo} + EW'(1)));

  // distances to the two bracketing entries
  assign dlo = (v_r >= e_lo) ? (v_r - e_lo) : (e_lo - v_r);
  assign dhi = (e_hi >= v_r) ? (e_hi - v_r) : (v_r - e_hi);

  // result fields for the finished transaction
  always_comb begin
    code_out_next  = 8'd0;
    value_out_next = 16'd0;
    status_next    = ntvc_pkg::ST_OK;
    case (op_r)
      ntvc_pkg::OP_ENC: begin
        code_out_next = ntvc_pkg::VALID_MARK | 8'(pick);
      end
      ntvc_pkg::OP_DEC: begin
        if (code_r != 8'd0) begin
          if ((code_r & ntvc_pkg::VALID_MARK) == 8'd0) begin
            status_next = ntvc_pkg::ST_NO_MARK;
          end else if (code_idx >= 8'(eff)) begin
            status_next = ntvc_pkg::ST_RANGE;
          end else begin
            value_out_next = 16'(rdata);
          end
        end
      end
      default: begin
        code_out_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op;
      idx_r  <= entry_index;
      ev_r   <= VALUE_BITS'(entry_value);
      v_r    <= VALUE_BITS'(dpi);
      code_r <= code;
      lo     <= '0;
      hi     <= IW'(eff - EW'(1));
    end
    // zero first entry is skipped when more than one entry is in use
    if (cmd.set_lo) begin
      lo <= (hi != '0 && rdata == '0) ? IW'(1) : '0;
    end
    if (cmd.take_lo) begin
      e_lo <= rdata;
    end
    if (cmd.take_hi) begin
      e_hi <= rdata;
    end
    if (cmd.take_mid) begin
      if (st.lt) begin
        hi   <= mid;
        e_hi <= rdata;
      end else begin
        lo   <= mid;
        e_lo <= rdata;
      end
    end
    if (cmd.pick_lo) begin
      pick <= lo;
    end
    if (cmd.pick_hi) begin
      pick <= hi;
    end
    if (cmd.pick_near) begin
      pick <= (dhi < dlo) ? hi : lo;  // tie goes to lower index
    end
    if (cmd.out_load) begin
      code_out  <= code_out_next;
      value_out <= value_out_next;
      status    <= status_next;
    end
  end

  `NTVC_ASSERT_SAME(a_mid_span, cmd.rd_en && cmd.rd_sel == ntvc_pkg::RD_MID,
    st.span_gt1, "mid probe without open interval")
  `NTVC_ASSERT_NEXT(a_mid_order, cmd.take_mid, lo < hi, "search bounds crossed")
  `NTVC_ASSERT_NEXT(a_enc_mark, cmd.out_load && op_r == ntvc_pkg::OP_ENC,
    code_out[7] && status == ntvc_pkg::ST_OK, "encode result lacks valid mark")

endmodule

// File: bench/tb_nearest_table_value_coder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_table_value_coder
// Self-checking bench for the nearest table value coder: a class model of the
// resolution table predicts every encode, decode and load reply, and random
// stalls on both channels shake the handshake.
// ---------------------------------------------------------------------------

module tb_nearest_table_value_coder;

  localparam int TABLE_DEPTH    = 128;
  localparam int ITEM_TARGET    = 1650;
  localparam int QUIET_TAIL     = 250;   // last transactions run with no idling
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off to back up the input
  // the watchdog limit covers the slowest transaction plus stalls; the long hold dominates
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int MAX_REPORTS    = 60;

  // one predicted reply
  typedef struct packed {
    logic [7:0]  enc;
    logic [15:0] dec_value;
    logic [1:0]  st;
  } reply_t;

  // -------------------------------------------------------------------------
  // Table model and reply checker
  // -------------------------------------------------------------------------
  class code_table_checker;
    logic [15:0] res_values [TABLE_DEPTH];
    int          size_reg;
    reply_t      awaited [$];
    int          errors;

    function new();
      size_reg = 1;
      errors   = 0;
    endfunction

    function void set_size(logic [7:0] v);
      size_reg = int'(v);
    endfunction

    // size register clamped to 1..TABLE_DEPTH
    function int used_entries();
      if (size_reg < 1) return 1;
      if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return size_reg;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // binary search for the entry nearest v
    function logic [6:0] nearest_entry(logic [15:0] v);
      int          lo, hi, mid;
      logic [15:0] dlo, dhi;
      lo = 0;
      hi = used_entries() - 1;
      // a zero first entry is skipped when more than one entry is in use
      if (hi > 0 && res_values[0] == 16'd0) lo = 1;
      if (v < res_values[lo]) return lo[6:0];
      if (v > res_values[hi]) return hi[6:0];
      while (hi - lo > 1) begin
        mid = (hi + lo) / 2;
        if (v < res_values[mid]) hi = mid;
        else lo = mid;
      end
      dhi = (res_values[hi] >= v) ? res_values[hi] - v : v - res_values[hi];
      dlo = (v >= res_values[lo]) ? v - res_values[lo] : res_values[lo] - v;
      // tie goes to the lower index
      return (dhi < dlo) ? hi[6:0] : lo[6:0];
    endfunction

    function void take_request(logic [1:0] k, logic [6:0] idx, logic [15:0] val,
                               logic [15:0] v, logic [7:0] c);
      reply_t r;
      r = '0;
      case (k)
        ntvc_pkg::OP_LOAD: res_values[idx] = val;
        ntvc_pkg::OP_ENC:  r.enc = ntvc_pkg::VALID_MARK | {1'b0, nearest_entry(v)};
        ntvc_pkg::OP_DEC: begin
          if (c != 8'd0) begin
            if ((c & ntvc_pkg::VALID_MARK) == 8'd0) r.st = ntvc_pkg::ST_NO_MARK;
            else if (int'(c & ntvc_pkg::INDEX_MASK) >= used_entries())
              r.st = ntvc_pkg::ST_RANGE;
            else r.dec_value = res_values[c[6:0]];
          end
        end
        default: ;
      endcase
      awaited = {awaited, r};
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_reply(logic [7:0] c, logic [15:0] v, logic [1:0] s);
      reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none", $time,
                   " actual code_out %0h value_out %0h status %0h", c, v, s);
        return;
      end
      want = awaited.pop_front();
      if (c !== want.enc)       mismatch("code_out", want.enc, c);
      if (v !== want.dec_value) mismatch("value_out", want.dec_value, v);
      if (s !== want.st)        mismatch("status", want.st, s);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, DUT signals, instance
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = ntvc_pkg::OP_LOAD;
  logic [6:0]  entry_index = 7'd0;
  logic [15:0] entry_value = 16'd0;
  logic [15:0] dpi = 16'd0;
  logic [7:0]  code = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  code_out;
  logic [15:0] value_out;
  logic [1:0]  status;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_table_value_coder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .dpi         (dpi),
    .code        (code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_out    (code_out),
    .value_out   (value_out),
    .status      (status)
  );

  code_table_checker sb = new();

  bit idle_on   = 1'b1;  // random gaps on both channels
  bit hold_long = 1'b0;  // request for one long receiver hold-off
  int items_sent = 0;
  int quiet_cycles = 0;

  // -------------------------------------------------------------------------
  // Monitor: every handshake is seen here at the clock edge it completes on.
  // Results are checked before the new request is noted; a result at an edge
  // always belongs to an older transaction.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_reply(code_out, value_out, status);
      if (in_valid && !in_stall) sb.take_request(op, entry_index, entry_value, dpi, code);
      if (cfg_we) sb.set_size(cfg_wdata);
    end
  end

  // Watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off on request
  // so the block fills up and pushes back on the sender.
  always begin
    @(posedge clk);
    if (hold_long) begin
      hold_long = 1'b0;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 3)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks. send_item returns at the edge where the transaction was
  // taken, with valid still high; the caller either offers the next item in
  // the same step or drops valid.
  // -------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] k, input logic [6:0] idx,
                           input logic [15:0] val, input logic [15:0] v,
                           input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= k;
    entry_index <= idx;
    entry_value <= val;
    dpi         <= v;
    code        <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry random bits
  task automatic load_entry(input int idx, input int val);
    send_item(ntvc_pkg::OP_LOAD, idx[6:0], val[15:0], 16'($urandom), 8'($urandom));
  endtask

  task automatic encode(input int v);
    send_item(ntvc_pkg::OP_ENC, 7'($urandom), 16'($urandom), v[15:0], 8'($urandom));
  endtask

  task automatic decode(input int c);
    send_item(ntvc_pkg::OP_DEC, 7'($urandom), 16'($urandom), 16'($urandom), c[7:0]);
  endtask

  // drop valid and wait until every reply is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(input int s);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= s[7:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ascending table, optionally with a zero first entry or fully scrambled
  task automatic load_table(input int n, input bit zero_first, input bit scrambled);
    int v;
    int val;
    v = zero_first ? 0 : $urandom_range(0, 3000);
    for (int i = 0; i < n; i++) begin
      val = scrambled ? $urandom_range(0, 65535) : v;
      load_entry(i, val);
      // zero steps give duplicate entries now and then
      if ($urandom_range(0, 7) != 0) v += $urandom_range(1, 2 * (65535 / n));
      if (v > 65535) v = 65535;
    end
  endtask

  task automatic random_item();
    int used;
    int pick;
    int i;
    int v;
    used = sb.used_entries();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535));
    end else if (pick < 65) begin
      i = $urandom_range(0, used - 1);
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = 65535;
        2, 3, 4: begin
          v = int'(sb.res_values[i]) + $urandom_range(0, 8) - 4;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
        end
        5, 6: begin
          // midpoint of two neighbors: exact tie when their sum is even
          if (i + 1 < used) v = (int'(sb.res_values[i]) + int'(sb.res_values[i + 1])) / 2;
          else v = sb.res_values[i];
        end
        default: v = $urandom_range(0, 65535);
      endcase
      encode(v);
    end else begin
      case ($urandom_range(0, 9))
        0:          v = 0;
        1, 2, 3, 4: v = ntvc_pkg::VALID_MARK | $urandom_range(0, used - 1);
        5:          v = ntvc_pkg::VALID_MARK | $urandom_range(0, 127);
        6:          v = $urandom_range(1, 127);        // valid mark missing
        default:    v = $urandom_range(0, 255);
      endcase
      decode(v);
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int s;
    int n;
    int phase;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed: single entry table ---
    write_size(1);
    load_entry(0, 1000);
    encode(0);
    encode(65535);
    encode(1000);
    decode(8'h00);               // code zero
    decode(8'h80);
    decode(8'h81);               // index beyond size
    decode(8'hFF);
    decode(8'h7F);               // no valid mark
    load_entry(0, 0);
    encode(5);                   // zero first entry still wins with one entry
    decode(8'h80);

    // --- directed: full table, entry i = 500 * i, zero first entry ---
    write_size(TABLE_DEPTH);
    for (int i = 0; i < TABLE_DEPTH; i++) load_entry(i, i * 500);
    encode(0);                   // below table, skips zero entry
    encode(1);
    encode(750);                 // tie between entries 1 and 2
    encode(63400);
    encode(65535);               // above table
    decode(8'hFF);
    load_entry(127, 65535);
    decode(8'hFF);

    // --- directed: two entries ---
    write_size(2);
    encode(0);                   // zero first entry skipped, lo meets hi
    decode(8'h81);
    decode(8'h82);
    load_entry(0, 100);
    encode(0);
    encode(300);                 // tie, lower index wins
    decode(8'h80);

    // --- random phases ---
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 6))
        0:       s = 1;
        1:       s = 2;
        2:       s = TABLE_DEPTH;
        3:       s = TABLE_DEPTH - 1;
        4:       s = $urandom_range(3, 16);
        default: s = $urandom_range(1, TABLE_DEPTH);
      endcase
      write_size(s);
      idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1)
        load_table(s, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
      if (phase == 2) hold_long = 1'b1;
      n = $urandom_range(20, 80);
      repeat (n) begin
        if (items_sent >= ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
        random_item();
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
